[rtl/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// tfn_pkg
// Widths, the reset value of the minimum length and the context record of the face
// normal pipeline; the widths are shared with its step units.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_W   = 16;
    localparam int FRAC_W    = 14;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * EDGE_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int MAG_W     = CROSS_W - 1;
    localparam int R_W       = 30;
    localparam int RSQ_W     = 2 * R_W;
    localparam int SUM_W     = RSQ_W + 2;
    localparam int ROOT_W    = R_W + 1;
    localparam int RREM_W    = ROOT_W + 3;
    localparam int NUM_W     = R_W + FRAC_W + 1;
    localparam int Q_W       = FRAC_W + 1;
    localparam int SQ_STEPS  = SUM_W / 2;
    localparam int DIV_STEPS = Q_W;
    localparam int LEN_W     = 16;
    localparam int SMALL_W   = 16;
    localparam int DSUM_W    = 2 * SMALL_W + 2;
    localparam int OUT_W     = 16;

    localparam logic [LEN_W-1:0] LEN_RESET = 16'd7;

    typedef struct packed {
        logic [2:0]          neg;
        logic [2:0][R_W-1:0] r;
        logic                deg;
    } norm_ctx_t;

endpackage

[rtl/tfn_sqrt_step.sv]
// ----------------------------------------------------------------------------
// tfn_sqrt_step
// One restoring square-root step: brings in two radicand bits, yields one
// root bit.
// ----------------------------------------------------------------------------
module tfn_sqrt_step
(
    input  logic [tfn_pkg::RREM_W-1:0] rem_in,
    input  logic [tfn_pkg::ROOT_W-1:0] root_in,
    input  logic [1:0]                 pair,
    output logic [tfn_pkg::RREM_W-1:0] rem_out,
    output logic [tfn_pkg::ROOT_W-1:0] root_out
);
    import tfn_pkg::*;

    logic [RREM_W-1:0] acc;
    logic [RREM_W-1:0] trial;

    always_comb
    begin
        acc   = {rem_in[RREM_W-3:0], pair};
        trial = {1'b0, root_in, 2'b01};
        if (acc >= trial)
        begin
            rem_out  = acc - trial;
            root_out = {root_in[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_out  = acc;
            root_out = {root_in[ROOT_W-2:0], 1'b0};
        end
    end

endmodule

[rtl/tfn_div_step.sv]
// ----------------------------------------------------------------------------
// tfn_div_step
// One restoring division step: shifts a numerator bit out of the low register
// into the remainder and shifts the quotient bit into the low register.
// ----------------------------------------------------------------------------
module tfn_div_step
(
    input  logic [tfn_pkg::ROOT_W-1:0] rem_in,
    input  logic [tfn_pkg::Q_W-1:0]    lo_in,
    input  logic [tfn_pkg::ROOT_W-1:0] divisor,
    output logic [tfn_pkg::ROOT_W-1:0] rem_out,
    output logic [tfn_pkg::Q_W-1:0]    lo_out
);
    import tfn_pkg::*;

    logic [ROOT_W:0] acc;
    logic [ROOT_W:0] diff;

    always_comb
    begin
        acc  = {rem_in, lo_in[Q_W-1]};
        diff = acc - {1'b0, divisor};
        if (acc >= {1'b0, divisor})
        begin
            rem_out = diff[ROOT_W-1:0];
            lo_out  = {lo_in[Q_W-2:0], 1'b1};
        end
        else
        begin
            rem_out = acc[ROOT_W-1:0];
            lo_out  = {lo_in[Q_W-2:0], 1'b0};
        end
    end

endmodule

[rtl/triangle_face_normal.sv]
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle: cross product of the edges b-a and c-a, normalized to
// signed Q1.14, with a degenerate test against a programmable minimum length.
// ----------------------------------------------------------------------------
// Takes one triangle per clock and returns one normal per clock while the
// output skid register is empty. The pipeline is made of the bit-serial square
// root (31 stages, one root bit each) and the three parallel dividers (15
// stages, one quotient bit each), plus six stages of edge, product, cross,
// shift, square and sum, one prepare stage and one output stage. An output skid
// register takes a finished normal that is not accepted, so the pipeline can
// advance past it; the pipeline holds only while that skid register is full.
// ----------------------------------------------------------------------------
module triangle_face_normal
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [tfn_pkg::LEN_W-1:0]  cfg_wr_data,   // min_length
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [143:0]               s_tdata,       // a_x a_y a_z b_x b_y b_z c_x c_y c_z
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [47:0]                m_tdata,       // normal_x normal_y normal_z
    output logic                       m_tuser        // degenerate
);
    import tfn_pkg::*;

    localparam int ST_SQRT = 6;
    localparam int ST_PREP = ST_SQRT + SQ_STEPS;
    localparam int ST_DIV  = ST_PREP + 1;
    localparam int ST_OUT  = ST_DIV + DIV_STEPS;
    localparam int NS      = ST_OUT + 1;

    logic [LEN_W-1:0] min_len_reg;
    logic [NS-1:0]    v_reg;
    logic             en;

    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic signed [PROD_W-1:0]  p_reg  [6];
    logic [MAG_W-1:0]          mag_reg [3];
    logic [2:0]                neg2_reg;
    logic [2:0][R_W-1:0]       r3_reg;
    logic [2:0]                neg3_reg;
    logic                      small_reg;
    logic [2*SMALL_W-1:0]      sq16_reg [3];
    logic [RSQ_W-1:0]          rsq_reg [3];
    norm_ctx_t                 ctx4_reg;
    logic [SUM_W-1:0]          sum_reg;
    norm_ctx_t                 ctx5_reg;

    logic [RREM_W-1:0]         sq_rem_reg  [SQ_STEPS];
    logic [ROOT_W-1:0]         sq_root_reg [SQ_STEPS];
    logic [SUM_W-1:0]          sq_x_reg    [SQ_STEPS];
    norm_ctx_t                 sq_ctx_reg  [SQ_STEPS];

    logic [ROOT_W-1:0]         dv_rem_reg [DIV_STEPS+1][3];
    logic [Q_W-1:0]            dv_lo_reg  [DIV_STEPS+1][3];
    logic [ROOT_W-1:0]         dv_l_reg   [DIV_STEPS+1];
    norm_ctx_t                 dv_ctx_reg [DIV_STEPS+1];

    logic [47:0]               out_data_reg;
    logic                      out_deg_reg;
    logic                      skid_v_reg;
    logic [47:0]               skid_data_reg;
    logic                      skid_deg_reg;

    logic signed [EDGE_W-1:0]  vtx [9];
    logic [MAG_W-1:0]          mag_or;
    logic [2:0]                shift_amt;
    logic [2*SMALL_W-1:0]      min_sq;
    logic [DSUM_W-1:0]         dsum;
    logic [ROOT_W-1:0]         len_c;
    logic [NUM_W-1:0]          num_c [3];
    logic [OUT_W-1:0]          comp_c [3];

    assign en       = ~skid_v_reg;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_len_reg <= LEN_RESET;
        else if (cfg_wr_en)
            min_len_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NS-2:0], s_tvalid};
    end

    // edges
    always_comb
    begin
        for (int i = 0; i < 9; i++)
            vtx[i] = EDGE_W'($signed(s_tdata[i*COORD_W +: COORD_W]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= vtx[3+i] - vtx[i];
                e2_reg[i] <= vtx[6+i] - vtx[i];
            end
        end
    end

    // products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= PROD_W'(e1_reg[1]) * PROD_W'(e2_reg[2]);
            p_reg[1] <= PROD_W'(e1_reg[2]) * PROD_W'(e2_reg[1]);
            p_reg[2] <= PROD_W'(e1_reg[2]) * PROD_W'(e2_reg[0]);
            p_reg[3] <= PROD_W'(e1_reg[0]) * PROD_W'(e2_reg[2]);
            p_reg[4] <= PROD_W'(e1_reg[0]) * PROD_W'(e2_reg[1]);
            p_reg[5] <= PROD_W'(e1_reg[1]) * PROD_W'(e2_reg[0]);
        end
    end

    // cross terms as sign and magnitude
    always_ff @(posedge clk)
    begin
        logic signed [CROSS_W-1:0] cr;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cr = CROSS_W'(p_reg[2*i]) - CROSS_W'(p_reg[2*i+1]);
                neg2_reg[i] <= cr[CROSS_W-1];
                mag_reg[i]  <= cr[CROSS_W-1] ? MAG_W'(-cr) : MAG_W'(cr);
            end
        end
    end

    // normalizing shift, low squares for the degenerate test
    always_comb
    begin
        mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2];
        if (mag_or[33])
            shift_amt = 3'd4;
        else if (mag_or[32])
            shift_amt = 3'd3;
        else if (mag_or[31])
            shift_amt = 3'd2;
        else if (mag_or[30])
            shift_amt = 3'd1;
        else
            shift_amt = 3'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg3_reg  <= neg2_reg;
            small_reg <= (mag_or[MAG_W-1:SMALL_W] == '0);
            for (int i = 0; i < 3; i++)
            begin
                r3_reg[i]   <= R_W'(mag_reg[i] >> shift_amt);
                sq16_reg[i] <= (2*SMALL_W)'(mag_reg[i][SMALL_W-1:0])
                             * (2*SMALL_W)'(mag_reg[i][SMALL_W-1:0]);
            end
        end
    end

    // squares, degenerate compare
    always_comb
    begin
        min_sq = (2*SMALL_W)'(min_len_reg) * (2*SMALL_W)'(min_len_reg);
        dsum   = DSUM_W'(sq16_reg[0]) + DSUM_W'(sq16_reg[1]) + DSUM_W'(sq16_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                rsq_reg[i] <= RSQ_W'(r3_reg[i]) * RSQ_W'(r3_reg[i]);
            ctx4_reg.neg <= neg3_reg;
            ctx4_reg.r   <= r3_reg;
            ctx4_reg.deg <= small_reg && (dsum <= DSUM_W'(min_sq));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= SUM_W'(rsq_reg[0]) + SUM_W'(rsq_reg[1]) + SUM_W'(rsq_reg[2]);
            ctx5_reg <= ctx4_reg;
        end
    end

    // square root, one root bit per stage
    genvar j, k;
    generate
        for (j = 0; j < SQ_STEPS; j++)
        begin : g_sqrt
            logic [RREM_W-1:0] rem_i;
            logic [ROOT_W-1:0] root_i;
            logic [SUM_W-1:0]  x_i;
            norm_ctx_t         ctx_i;
            logic [RREM_W-1:0] rem_o;
            logic [ROOT_W-1:0] root_o;

            if (j == 0)
            begin : g_first
                assign rem_i  = '0;
                assign root_i = '0;
                assign x_i    = sum_reg;
                assign ctx_i  = ctx5_reg;
            end
            else
            begin : g_next
                assign rem_i  = sq_rem_reg[j-1];
                assign root_i = sq_root_reg[j-1];
                assign x_i    = sq_x_reg[j-1];
                assign ctx_i  = sq_ctx_reg[j-1];
            end

            tfn_sqrt_step u_step
            (
                .rem_in   (rem_i),
                .root_in  (root_i),
                .pair     (x_i[SUM_W-1 -: 2]),
                .rem_out  (rem_o),
                .root_out (root_o)
            );

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rem_reg[j]  <= rem_o;
                    sq_root_reg[j] <= root_o;
                    sq_x_reg[j]    <= {x_i[SUM_W-3:0], 2'b00};
                    sq_ctx_reg[j]  <= ctx_i;
                end
            end
        end
    endgenerate

    // prepare rounded numerators
    always_comb
    begin
        len_c = (sq_root_reg[SQ_STEPS-1] == '0) ? ROOT_W'(1) : sq_root_reg[SQ_STEPS-1];
        for (int i = 0; i < 3; i++)
            num_c[i] = {1'b0, sq_ctx_reg[SQ_STEPS-1].r[i], FRAC_W'(0)}
                     + NUM_W'(len_c >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= ROOT_W'(num_c[i][NUM_W-1:Q_W]);
                dv_lo_reg[0][i]  <= num_c[i][Q_W-1:0];
            end
            dv_l_reg[0]   <= len_c;
            dv_ctx_reg[0] <= sq_ctx_reg[SQ_STEPS-1];
        end
    end

    // three dividers, one quotient bit per stage
    generate
        for (j = 0; j < DIV_STEPS; j++)
        begin : g_div
            for (k = 0; k < 3; k++)
            begin : g_lane
                logic [ROOT_W-1:0] rem_o;
                logic [Q_W-1:0]    lo_o;

                tfn_div_step u_step
                (
                    .rem_in  (dv_rem_reg[j][k]),
                    .lo_in   (dv_lo_reg[j][k]),
                    .divisor (dv_l_reg[j]),
                    .rem_out (rem_o),
                    .lo_out  (lo_o)
                );

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        dv_rem_reg[j+1][k] <= rem_o;
                        dv_lo_reg[j+1][k]  <= lo_o;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_l_reg[j+1]   <= dv_l_reg[j];
                    dv_ctx_reg[j+1] <= dv_ctx_reg[j];
                end
            end
        end
    endgenerate

    // apply sign, select default normal
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            comp_c[i] = dv_ctx_reg[DIV_STEPS].neg[i] ? -OUT_W'(dv_lo_reg[DIV_STEPS][i])
                                                     : OUT_W'(dv_lo_reg[DIV_STEPS][i]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_deg_reg <= dv_ctx_reg[DIV_STEPS].deg;
            if (dv_ctx_reg[DIV_STEPS].deg)
                out_data_reg <= {OUT_W'(0), OUT_W'(1) << FRAC_W, OUT_W'(0)};
            else
                out_data_reg <= {comp_c[2], comp_c[1], comp_c[0]};
        end
    end

    // output skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_v_reg <= 1'b0;
        else if (skid_v_reg)
            skid_v_reg <= ~m_tready;
        else
            skid_v_reg <= v_reg[NS-1] & ~m_tready;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_v_reg && v_reg[NS-1] && !m_tready)
        begin
            skid_data_reg <= out_data_reg;
            skid_deg_reg  <= out_deg_reg;
        end
    end

    assign m_tvalid = skid_v_reg | v_reg[NS-1];
    assign m_tdata  = skid_v_reg ? skid_data_reg : out_data_reg;
    assign m_tuser  = skid_v_reg ? skid_deg_reg : out_deg_reg;

    a_deg_default: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == {16'd0, 16'd16384, 16'd0}))
        else $error("degenerate transfer without default normal");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |->
            ($signed(m_tdata[15:0])  <= 16384 && $signed(m_tdata[15:0])  >= -16384 &&
             $signed(m_tdata[31:16]) <= 16384 && $signed(m_tdata[31:16]) >= -16384 &&
             $signed(m_tdata[47:32]) <= 16384 && $signed(m_tdata[47:32]) >= -16384))
        else $error("normal component out of unit range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |=> $stable(v_reg))
        else $error("pipeline advanced while skid register full");

endmodule
